/* design/rcss_pkg.sv */
package rcss_pkg;

   localparam int CACHE_SLOTS = 16384;
   localparam int NODE_IDS    = 1048576;

   localparam int SLOT_W = $clog2(CACHE_SLOTS);
   localparam int NODE_W = $clog2(NODE_IDS);
   localparam int SIZE_W = 15;
   localparam int SMAP_W = 16;
   localparam int NMAP_W = 21;
   localparam int AGE_W  = 16;
   localparam int CSR_W  = 21;
   localparam int CSR_IDX_W = 2;

   localparam int CLEAR_N = (NODE_IDS > CACHE_SLOTS) ? NODE_IDS : CACHE_SLOTS;
   localparam int CLEAR_W = $clog2(CLEAR_N);

   localparam logic [CSR_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NO_SLOT_MARK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NO_NODE_MARK = 2'd2;

   localparam logic [SIZE_W-1:0] SLOTS_RST     = 15'd16384;
   localparam logic [SMAP_W-1:0] SLOT_MARK_RST = 16'hFFFF;
   localparam logic [NMAP_W-1:0] NODE_MARK_RST = 21'h1FFFFF;

   typedef struct packed {
      logic clear_step;
      logic lookup;
      logic invalidate;
      logic store;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

/* design/rcss_ctrl.sv */
module rcss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_stall,
   input  rcss_pkg::dp_status_type status,
   output rcss_pkg::ctrl_cmd_type  cmd,
   output logic                   req_stall,
   output logic                   rsp_valid
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INV,
      S_STORE,
      S_HOLD
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;
   logic      load;

   assign accept   = (state_ff == S_IDLE) && req_valid && !req_stall_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = ((state_ff == S_STORE) || (state_ff == S_HOLD)) && out_free;

   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.lookup     = accept;
      cmd.invalidate = (state_ff == S_INV);
      cmd.store      = (state_ff == S_STORE);
      cmd.load_rsp   = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (status.clear_last) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff     <= S_INV;
                  req_stall_ff <= 1'b1;
               end
            end
            S_INV: begin
               state_ff <= S_STORE;
            end
            S_STORE, S_HOLD: begin
               if (out_free) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end else begin
                  state_ff <= S_HOLD;
               end
            end
            default: begin
               state_ff     <= S_CLEAR;
               req_stall_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/rcss_dp.sv */
module rcss_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rcss_pkg::ctrl_cmd_type               cmd,
   output rcss_pkg::dp_status_type              status,
   input  logic                                csr_write,
   input  logic [rcss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcss_pkg::CSR_W-1:0]          csr_data,
   input  logic [19:0]                         req_node_id,
   output logic [13:0]                         rsp_stored_slot,
   output logic                                rsp_was_cached,
   output logic [13:0]                         rsp_old_slot,
   output logic                                rsp_evicted_valid,
   output logic [19:0]                         rsp_evicted_node
);

   logic [rcss_pkg::SIZE_W-1:0]  slots_ff;
   logic [rcss_pkg::SMAP_W-1:0]  slot_mark_ff;
   logic [rcss_pkg::NMAP_W-1:0]  node_mark_ff;
   logic [rcss_pkg::SIZE_W-1:0]  write_slot_ff;
   logic [rcss_pkg::CLEAR_W-1:0] clear_cnt_ff;

   logic [rcss_pkg::SMAP_W-1:0] smap_mem [rcss_pkg::NODE_IDS];
   logic [rcss_pkg::NMAP_W-1:0] nmap_mem [rcss_pkg::CACHE_SLOTS];
   logic [rcss_pkg::AGE_W-1:0]  age_mem  [rcss_pkg::CACHE_SLOTS];

   logic [rcss_pkg::SMAP_W-1:0] smap_rd_ff;
   logic [rcss_pkg::NMAP_W-1:0] nmap_rd_ff;
   logic [19:0]                 node_ff;
   logic [rcss_pkg::SIZE_W-1:0] w_ff;

   logic                        res_cached_ff;
   logic [13:0]                 res_old_ff;
   logic                        res_evict_ff;
   logic [19:0]                 res_ev_node_ff;

   logic [13:0] rsp_stored_slot_ff;
   logic        rsp_was_cached_ff;
   logic [13:0] rsp_old_slot_ff;
   logic        rsp_evicted_valid_ff;
   logic [19:0] rsp_evicted_node_ff;

   logic [rcss_pkg::SIZE_W-1:0] size;
   logic [rcss_pkg::SIZE_W-1:0] w_eff;
   logic [rcss_pkg::SIZE_W-1:0] w_next;
   logic [rcss_pkg::SIZE_W-1:0] w_inc;
   logic                        node_ok;
   logic                        cached;
   logic [rcss_pkg::NMAP_W-1:0] prev;
   logic                        evict;

   logic                         smap_we;
   logic [rcss_pkg::NODE_W-1:0]  smap_waddr;
   logic [rcss_pkg::SMAP_W-1:0]  smap_wdata;
   logic                         nmap_we;
   logic [rcss_pkg::SLOT_W-1:0]  nmap_waddr;
   logic [rcss_pkg::NMAP_W-1:0]  nmap_wdata;
   logic                         age_we;
   logic [rcss_pkg::SLOT_W-1:0]  age_waddr;
   logic                         clear_in_slots;

   // effective ring size and pointer
   always_comb begin
      if (slots_ff == '0) begin
         size = rcss_pkg::SIZE_W'(1);
      end else if (32'(slots_ff) > rcss_pkg::CACHE_SLOTS) begin
         size = rcss_pkg::SIZE_W'(rcss_pkg::CACHE_SLOTS);
      end else begin
         size = slots_ff;
      end
      w_eff  = (write_slot_ff >= size) ? '0 : write_slot_ff;
      w_inc  = w_eff + rcss_pkg::SIZE_W'(1);
      w_next = (w_inc >= size) ? '0 : w_inc;
   end

   assign node_ok = 32'(node_ff) < rcss_pkg::NODE_IDS;
   assign cached  = node_ok && (smap_rd_ff != slot_mark_ff)
                    && (32'(smap_rd_ff) < rcss_pkg::CACHE_SLOTS);
   // slot just emptied by the invalidation reads back as empty
   assign prev    = (cached && (smap_rd_ff[rcss_pkg::SLOT_W-1:0] == w_ff[rcss_pkg::SLOT_W-1:0]))
                    ? node_mark_ff : nmap_rd_ff;
   assign evict   = (prev != node_mark_ff) && (32'(prev) < rcss_pkg::NODE_IDS);

   assign clear_in_slots = 32'(clear_cnt_ff) < rcss_pkg::CACHE_SLOTS;
   assign status.clear_last = (clear_cnt_ff == rcss_pkg::CLEAR_W'(rcss_pkg::CLEAR_N - 1));

   always_comb begin
      smap_we    = 1'b0;
      smap_waddr = clear_cnt_ff[rcss_pkg::NODE_W-1:0];
      smap_wdata = rcss_pkg::SLOT_MARK_RST;
      nmap_we    = 1'b0;
      nmap_waddr = clear_cnt_ff[rcss_pkg::SLOT_W-1:0];
      nmap_wdata = rcss_pkg::NODE_MARK_RST;
      age_we     = 1'b0;
      age_waddr  = clear_cnt_ff[rcss_pkg::SLOT_W-1:0];
      if (cmd.clear_step) begin
         smap_we = 1'b1;
         nmap_we = clear_in_slots;
         age_we  = clear_in_slots;
      end else if (cmd.invalidate) begin
         smap_we    = evict;
         smap_waddr = prev[rcss_pkg::NODE_W-1:0];
         smap_wdata = slot_mark_ff;
         nmap_we    = cached;
         nmap_waddr = smap_rd_ff[rcss_pkg::SLOT_W-1:0];
         nmap_wdata = node_mark_ff;
      end else if (cmd.store) begin
         smap_we    = node_ok;
         smap_waddr = node_ff[rcss_pkg::NODE_W-1:0];
         smap_wdata = rcss_pkg::SMAP_W'(w_ff);
         nmap_we    = 1'b1;
         nmap_waddr = w_ff[rcss_pkg::SLOT_W-1:0];
         nmap_wdata = rcss_pkg::NMAP_W'(node_ff);
         age_we     = 1'b1;
         age_waddr  = w_ff[rcss_pkg::SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (smap_we) begin
         smap_mem[smap_waddr] <= smap_wdata;
      end
      if (cmd.lookup) begin
         smap_rd_ff <= smap_mem[req_node_id[rcss_pkg::NODE_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (nmap_we) begin
         nmap_mem[nmap_waddr] <= nmap_wdata;
      end
      if (cmd.lookup) begin
         nmap_rd_ff <= nmap_mem[w_eff[rcss_pkg::SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_waddr] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff      <= rcss_pkg::SLOTS_RST;
         slot_mark_ff  <= rcss_pkg::SLOT_MARK_RST;
         node_mark_ff  <= rcss_pkg::NODE_MARK_RST;
         write_slot_ff <= '0;
         clear_cnt_ff  <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               rcss_pkg::REG_SLOTS_IN_USE: slots_ff     <= csr_data[rcss_pkg::SIZE_W-1:0];
               rcss_pkg::REG_NO_SLOT_MARK: slot_mark_ff <= csr_data[rcss_pkg::SMAP_W-1:0];
               rcss_pkg::REG_NO_NODE_MARK: node_mark_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + rcss_pkg::CLEAR_W'(1);
         end
         if (cmd.lookup) begin
            write_slot_ff <= w_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         node_ff <= req_node_id;
         w_ff    <= w_eff;
      end
      if (cmd.invalidate) begin
         res_cached_ff  <= cached;
         res_old_ff     <= cached ? smap_rd_ff[13:0] : 14'd0;
         res_evict_ff   <= evict;
         res_ev_node_ff <= evict ? prev[19:0] : 20'd0;
      end
      if (cmd.load_rsp) begin
         rsp_stored_slot_ff   <= w_ff[13:0];
         rsp_was_cached_ff    <= res_cached_ff;
         rsp_old_slot_ff      <= res_old_ff;
         rsp_evicted_valid_ff <= res_evict_ff;
         rsp_evicted_node_ff  <= res_ev_node_ff;
      end
   end

   assign rsp_stored_slot   = rsp_stored_slot_ff;
   assign rsp_was_cached    = rsp_was_cached_ff;
   assign rsp_old_slot      = rsp_old_slot_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_node  = rsp_evicted_node_ff;

endmodule

/* design/ring_cache_slot_store_unit.sv */
// Flow: an accepted item passes the invalidate and store states; its result is
//   registered as the store state is left, and a new item is taken only then;
//   each map has one write port and an item needs two writes to each.
// Reset: synchronous; a clearing pass then sweeps both maps, req_stall held
//   high meanwhile, csr writes taken throughout.
module ring_cache_slot_store_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [rcss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcss_pkg::CSR_W-1:0]     csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [19:0]                    req_node_id,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [13:0]                    rsp_stored_slot,
   output logic                           rsp_was_cached,
   output logic [13:0]                    rsp_old_slot,
   output logic                           rsp_evicted_valid,
   output logic [19:0]                    rsp_evicted_node
);

   rcss_pkg::ctrl_cmd_type  cmd;
   rcss_pkg::dp_status_type status;

   rcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   rcss_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_node_id       (req_node_id),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_was_cached    (rsp_was_cached),
      .rsp_old_slot      (rsp_old_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_node  (rsp_evicted_node)
   );

endmodule

/* design/rcss_checker.sv */
module rcss_bus_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_stored_slot,
   input logic        rsp_was_cached,
   input logic [13:0] rsp_old_slot,
   input logic        rsp_evicted_valid,
   input logic [19:0] rsp_evicted_node
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_stored_slot)
         && $stable(rsp_was_cached) && $stable(rsp_old_slot)
         && $stable(rsp_evicted_valid) && $stable(rsp_evicted_node))
      else $error("result changed while stalled");

   a_old_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_cached |-> rsp_old_slot == 14'd0)
      else $error("old_slot set without was_cached");

   a_ev_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_node == 20'd0)
      else $error("evicted_node set without evicted_valid");

   // one item in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("not quiet after reset");

endmodule

bind ring_cache_slot_store_unit rcss_bus_checker u_rcss_checker (.*);

/* dv/rcss_checker.sv */
module rcss_checker
   import rcss_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [19:0]          req_node_id,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [13:0]          rsp_stored_slot,
   input  logic                 rsp_was_cached,
   input  logic [13:0]          rsp_old_slot,
   input  logic                 rsp_evicted_valid,
   input  logic [19:0]          rsp_evicted_node,
   output int unsigned          mismatch_count,
   output int unsigned          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [13:0] slot;
      logic        hit;
      logic [13:0] old_slot;
      logic        evicted;
      logic [19:0] victim;
   } placement_type;

   // node -> slot; an absent entry still holds the reset mark
   logic [SMAP_W-1:0] slot_map [bit [19:0]];
   logic [NMAP_W-1:0] node_map [CACHE_SLOTS];
   int unsigned       write_ptr;
   logic [SIZE_W-1:0] ring_slots;
   logic [SMAP_W-1:0] slot_mark;
   logic [NMAP_W-1:0] node_mark;
   placement_type     expected_results[$];
   int unsigned       fails;

   initial begin
      mismatch_count = 0;
      outstanding = 0;
      fails = 0;
   end

   function automatic placement_type place_node(logic [19:0] node);
      placement_type     r;
      logic [SMAP_W-1:0] held;
      logic [NMAP_W-1:0] prev;
      int unsigned       size;
      int unsigned       w;
      r = '0;
      size = ring_slots;
      if (size == 0) size = 1;
      if (size > CACHE_SLOTS) size = CACHE_SLOTS;
      held = slot_map.exists(node) ? slot_map[node] : SLOT_MARK_RST;
      if (held != slot_mark && held < CACHE_SLOTS) begin
         r.hit = 1'b1;
         r.old_slot = held[13:0];
         node_map[held[13:0]] = node_mark;
      end
      w = write_ptr;
      if (w >= size) w = 0;
      prev = node_map[w[13:0]];
      if (prev != node_mark && prev < NODE_IDS) begin
         r.evicted = 1'b1;
         r.victim = prev[19:0];
         slot_map[prev[19:0]] = slot_mark;
      end
      node_map[w[13:0]] = {1'b0, node};
      slot_map[node] = w[15:0];
      r.slot = w[13:0];
      w++;
      if (w >= size) w = 0;
      write_ptr = w;
      return r;
   endfunction

   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (reset) begin
         slot_map.delete();
         foreach (node_map[i]) node_map[i] = NODE_MARK_RST;
         write_ptr = 0;
         ring_slots = SLOTS_RST;
         slot_mark = SLOT_MARK_RST;
         node_mark = NODE_MARK_RST;
         expected_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_SLOTS_IN_USE: ring_slots = csr_data[SIZE_W-1:0];
               REG_NO_SLOT_MARK: slot_mark = csr_data[SMAP_W-1:0];
               REG_NO_NODE_MARK: node_mark = csr_data[NMAP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results.insert(expected_results.size(), place_node(req_node_id));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_stored_slot, rsp_was_cached, rsp_old_slot,
                   rsp_evicted_valid, rsp_evicted_node};
            if (expected_results.size() == 0) begin
               $error("result with none expected: slot %0d node %0d",
                      rsp_stored_slot, rsp_evicted_node);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (got.slot !== want.slot) begin
                  $error("stored_slot: expected %0d, got %0d", want.slot, got.slot);
                  fails++;
               end
               if (got.hit !== want.hit) begin
                  $error("was_cached: expected %0d, got %0d", want.hit, got.hit);
                  fails++;
               end
               if (got.old_slot !== want.old_slot) begin
                  $error("old_slot: expected %0d, got %0d", want.old_slot, got.old_slot);
                  fails++;
               end
               if (got.evicted !== want.evicted) begin
                  $error("evicted_valid: expected %0d, got %0d", want.evicted, got.evicted);
                  fails++;
               end
               if (got.victim !== want.victim) begin
                  $error("evicted_node: expected %0d, got %0d", want.victim, got.victim);
                  fails++;
               end
            end
         end
      end
      outstanding <= expected_results.size();
      mismatch_count <= fails;
   end

endmodule

/* dv/tb_top.sv */
module tb_top;
   import rcss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_SLOTS_IN_USE;
   logic [CSR_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [19:0]          req_node_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [13:0]          rsp_stored_slot;
   logic                 rsp_was_cached;
   logic [13:0]          rsp_old_slot;
   logic                 rsp_evicted_valid;
   logic [19:0]          rsp_evicted_node;
   int unsigned          mismatch_count;
   int unsigned          outstanding;

   int unsigned          items_sent = 0;
   bit                   gaps_off = 1'b0;
   int unsigned          ring_eff = CACHE_SLOTS;
   logic [NMAP_W-1:0]    cur_node_mark = NODE_MARK_RST;

   ring_cache_slot_store_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_node_id       (req_node_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_was_cached    (rsp_was_cached),
      .rsp_old_slot      (rsp_old_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_node  (rsp_evicted_node)
   );

   rcss_checker slot_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_node_id       (req_node_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_was_cached    (rsp_was_cached),
      .rsp_old_slot      (rsp_old_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_node  (rsp_evicted_node),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   always #4 clock = ~clock;

   task automatic send_node(input logic [19:0] node);
      int unsigned gap;
      gap = gaps_off ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_node_id = node;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [SIZE_W-1:0] size, input logic [SMAP_W-1:0] smark,
                             input logic [NMAP_W-1:0] nmark);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = REG_SLOTS_IN_USE;
      csr_data = CSR_W'(size);
      @(negedge clock);
      csr_index = REG_NO_SLOT_MARK;
      csr_data = CSR_W'(smark);
      @(negedge clock);
      csr_index = REG_NO_NODE_MARK;
      csr_data = CSR_W'(nmark);
      @(negedge clock);
      csr_write = 1'b0;
      ring_eff = (size == 0) ? 1 : (size > CACHE_SLOTS) ? CACHE_SLOTS : size;
      cur_node_mark = nmark;
   endtask

   // mostly a small pool so nodes come back and slots get evicted
   function automatic logic [19:0] pick_node();
      int unsigned r;
      int unsigned pool;
      r = $urandom_range(0, 9);
      pool = (ring_eff <= 32) ? 2 * ring_eff + 3 : 48;
      if (r < 7) return 20'($urandom_range(0, pool));
      if (r == 7) return cur_node_mark[19:0];
      return 20'($urandom_range(0, 1048575));
   endfunction

   task automatic random_phase();
      logic [SIZE_W-1:0] size;
      logic [SMAP_W-1:0] smark;
      logic [NMAP_W-1:0] nmark;
      case ($urandom_range(0, 9))
         0: size = 15'd1;
         1: size = 15'd2;
         2: size = 15'd3;
         3: size = 15'd4;
         4: size = 15'd8;
         5: size = 15'd16;
         6: size = SIZE_W'($urandom_range(1, 40));
         7: size = 15'd16384;
         8: size = 15'd0;
         default: size = 15'h7FFF;
      endcase
      case ($urandom_range(0, 7))
         0: smark = 16'hFFFF;
         1: smark = 16'h0000;
         2: smark = 16'h0001;
         3: smark = 16'h7FFF;
         4: smark = 16'h8000;
         5: smark = SMAP_W'($urandom_range(0, 3));
         6: smark = SMAP_W'($urandom_range(0, 65535));
         default: smark = 16'h3FFF;
      endcase
      case ($urandom_range(0, 5))
         0: nmark = 21'h1FFFFF;
         1: nmark = 21'h000000;
         2: nmark = 21'h100000;
         3: nmark = 21'h0FFFFF;
         4: nmark = NMAP_W'($urandom_range(0, 7));
         default: nmark = NMAP_W'($urandom_range(0, 2097151));
      endcase
      set_config(size, smark, nmark);
      repeat (103) send_node(pick_node());
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // maps are swept after reset; wait for the input to open
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // reset settings, full ring
      send_node(20'h00000);
      send_node(20'hFFFFF);
      send_node(20'h00000);
      send_node(20'hAAAAA);
      send_node(20'h55555);
      send_node(20'hFFFFF);
      send_node(20'h12345);
      drain();

      // ring shrunk under the pointer, eviction, node already in its write slot
      set_config(15'd2, SLOT_MARK_RST, NODE_MARK_RST);
      send_node(20'd100);
      send_node(20'd101);
      send_node(20'd102);
      send_node(20'd101);
      send_node(20'd0);
      drain();

      // zero size acts as one slot; old reverse entries become stale
      set_config(15'd0, 16'h0000, 21'h100005);
      send_node(20'd7);
      send_node(20'd8);
      send_node(20'd7);
      drain();

      // node equal to the empty-slot mark
      set_config(15'd3, 16'h8000, 21'h0FFFFF);
      send_node(20'hFFFFF);
      send_node(20'd1);
      send_node(20'd2);
      send_node(20'd3);
      drain();

      // oversized ring acts as the full ring
      set_config(15'h7FFF, 16'h7FFF, 21'h100000);
      send_node(20'd3);
      send_node(20'h80000);
      drain();

      for (int p = 0; p < 10; p++) begin
         gaps_off = (p == 4);
         random_phase();
      end
      gaps_off = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      int unsigned hold;
      bit          long_done;
      long_done = 1'b0;
      forever begin
         hold = gaps_off ? 0 : $urandom_range(0, 3);
         if (!long_done && items_sent >= 300) begin
            hold = 300;
            long_done = 1'b1;
         end
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
design/rcss_pkg.sv
design/rcss_ctrl.sv
design/rcss_dp.sv
design/ring_cache_slot_store_unit.sv
design/rcss_checker.sv
dv/rcss_checker.sv
dv/tb_top.sv
